@@ design/hcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcd_pkg: shared constants and helpers for the chunked body decoder
// character codes, chunk count width and the hex digit decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

    // width of the remaining chunk byte counter (range 28 to 33)
    localparam int unsigned CHUNK_COUNT_BITS = 28;

    // a count above this before the next shift is an oversized chunk
    localparam logic [32:0] COUNT_LIMIT = 33'h0_00FF_FFFF;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // packed result beat width
    localparam int unsigned OUT_DATA_BITS = 16;

    typedef logic [CHUNK_COUNT_BITS-1:0] chunk_count_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // ascii hex digit decode, upper and lower case
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            d.valid = 1'b1;
            d.value = b[3:0];
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            d.valid = 1'b1;
            d.value = 4'(b[2:0] + 3'd1) + 4'd8;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ design/http_chunked_decoder_top.sv @@
// ----------------------------------------------------------------------------
// http_chunked_decoder_top: byte-serial http/1.1 chunked body decoder
// takes one encoded body byte per beat and returns one status beat per byte
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+---------------------------------------------------------
//  s_       | in  | tdata[7:0] in_byte
//  m_       | out | tdata: consumed, payload_byte[7:0], body_done,
//           |     |        format_error, zero fill; tuser: payload_valid
//
//  one input byte is taken per cycle while s_tready is high; its result
//  beat appears in the cycle after acceptance
//  the decode state is updated in the same edge that accepts the byte, set
//  by a single pass through the size, data, crlf and trailer logic
//  a stalled result register blocks the input only while it is full and
//  m_tready is low; s_tready = !m_tvalid || m_tready
//  aresetn (synchronous, active low) returns to the size line phase and
//  drops m_tvalid
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_decoder_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // in_byte[7:0]
    input  wire logic [7:0]                          s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // consumed, payload_byte[8:1], body_done[9], format_error[10], zeros
    output logic [hcd_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    // payload_valid
    output logic                                     m_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready
);

    import hcd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_DCRLF   = 3'd2,
        PH_TRAILER = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    // decode state
    phase_t       phase_reg, phase_next;
    chunk_count_t chunk_reg, chunk_next;
    logic         stop_scan_reg, stop_scan_next;
    logic         got_digit_reg, got_digit_next;
    logic         blank_reg, blank_next;

    // result register
    logic                     m_valid_reg;
    logic [OUT_DATA_BITS-1:0] m_data_reg, m_data_next;
    logic                     m_user_reg, m_user_next;

    logic       in_beat;
    logic       consumed;
    logic       pvalid;
    logic [7:0] pbyte;
    hex_digit_t digit;
    logic       over_limit;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    assign digit      = hex_decode(s_tdata);
    assign over_limit = 33'(chunk_reg) > COUNT_LIMIT;

    // one step of the decoder for the byte on s_tdata
    always_comb begin
        phase_next      = phase_reg;
        chunk_next      = chunk_reg;
        stop_scan_next  = stop_scan_reg;
        got_digit_next  = got_digit_reg;
        blank_next      = blank_reg;
        consumed        = 1'b1;
        pvalid          = 1'b0;
        pbyte           = 8'd0;

        case (phase_reg)
            PH_SIZE: begin
                if (digit.valid && !stop_scan_reg) begin
                    if (over_limit) begin
                        phase_next = PH_ERROR;
                        consumed   = 1'b0;
                    end else begin
                        chunk_next     = {chunk_reg[CHUNK_COUNT_BITS-5:0], digit.value};
                        got_digit_next = 1'b1;
                    end
                end else if (s_tdata == CH_LF) begin
                    if (!got_digit_reg) begin
                        phase_next = PH_ERROR;
                        consumed   = 1'b0;
                    end else begin
                        stop_scan_next = 1'b0;
                        got_digit_next = 1'b0;
                        if (chunk_reg == '0) begin
                            phase_next = PH_TRAILER;
                            blank_next = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end else begin
                    // cr, extension, any other non-digit, or a digit after the scan stopped
                    stop_scan_next = 1'b1;
                end
            end
            PH_DATA, PH_DCRLF: begin
                if (phase_reg == PH_DATA && chunk_reg != '0) begin
                    pvalid     = 1'b1;
                    pbyte      = s_tdata;
                    chunk_next = chunk_reg - 1'b1;
                    if (chunk_reg == chunk_count_t'(1)) begin
                        phase_next = PH_DCRLF;
                    end
                end else if (s_tdata == CH_LF) begin
                    phase_next = PH_SIZE;
                    chunk_next = '0;
                end else begin
                    phase_next = PH_DCRLF;
                end
            end
            PH_TRAILER: begin
                if (s_tdata == CH_LF) begin
                    if (blank_reg) begin
                        phase_next = PH_DONE;
                    end else begin
                        blank_next = 1'b1;
                    end
                end else if (s_tdata != CH_CR) begin
                    blank_next = 1'b0;
                end
            end
            PH_DONE: begin
                consumed = 1'b0;
            end
            default: begin
                // error, or a code that cannot occur
                phase_next = PH_ERROR;
                consumed   = 1'b0;
            end
        endcase

        m_data_next = {(OUT_DATA_BITS - 11)'(0),
                       phase_next == PH_ERROR,
                       phase_next == PH_DONE,
                       pbyte,
                       consumed};
        m_user_next = pvalid;
    end

    // decode state and the result register, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE;
            chunk_reg      <= '0;
            stop_scan_reg  <= 1'b0;
            got_digit_reg  <= 1'b0;
            blank_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= 1'b0;
        end else begin
            if (in_beat) begin
                phase_reg      <= phase_next;
                chunk_reg      <= chunk_next;
                stop_scan_reg  <= stop_scan_next;
                got_digit_reg  <= got_digit_next;
                blank_reg      <= blank_next;
                m_valid_reg    <= 1'b1;
                m_data_reg     <= m_data_next;
                m_user_reg     <= m_user_next;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // every accepted byte leaves a result beat behind it
    a_beat_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> m_valid_reg)
        else $error("accepted byte produced no result beat");

    // the data phase always has bytes left to pass
    a_data_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> chunk_reg != '0)
        else $error("data phase with zero remaining count");

    // done and error are terminal
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE || phase_reg == PH_ERROR) |=> $stable(phase_reg))
        else $error("left a terminal phase");

    // a payload byte is always a consumed byte and never flagged as an error
    a_payload_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg) |-> (m_data_reg[0] && !m_data_reg[10]))
        else $error("payload beat not consumed or flagged as error");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the chunked body decoder
// feeds one long chunked body, byte per beat, and checks every status beat
// against a hand-typed status or a cycle-free model of the decoder in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import hcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        SIZE_LINE  = 3'd0,
        CHUNK_DATA = 3'd1,
        DATA_CRLF  = 3'd2,
        TRAILER    = 3'd3,
        BODY_DONE  = 3'd4,
        FORMAT_ERR = 3'd5
    } dec_phase_t;

    // one status beat as the decoder reports it
    typedef struct packed {
        logic       consumed;
        logic       pvalid;
        logic [7:0] pbyte;
        logic       done;
        logic       ferr;
    } beat_status_t;

    // one encoded byte; status typed in by hand when fixed is set
    typedef struct packed {
        logic [7:0]   b;
        logic         fixed;
        beat_status_t st;
    } body_byte_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic [7:0]               s_tdata  = 8'h00;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;

    // decoder state as the bench tracks it
    dec_phase_t   dec_phase     = SIZE_LINE;
    chunk_count_t chunk_left    = '0;
    logic         stop_scan     = 1'b0;
    logic         got_digit     = 1'b0;
    logic         blank_line    = 1'b0;

    body_byte_t   body_q[$];
    beat_status_t expected_status_q[$];

    int errors        = 0;
    int rx_beats      = 0;
    int payload_beats = 0;
    int chunks        = 0;
    int stall_cycles  = 0;
    bit long_hold_done = 1'b0;
    string ending_name;

    // directed opening: size lines with extensions, payload extremes,
    // cr and lf as payload, lenient and bare line ends after data
    body_byte_t directed_tbl [26] = '{
        '{"1",     1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},   // first byte after reset
        '{CH_CR,   1'b0, '0},
        '{CH_LF,   1'b0, '0},
        '{8'h00,   1'b1, '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0}},   // lowest payload byte
        '{CH_CR,   1'b0, '0},
        '{CH_LF,   1'b0, '0},
        '{"0",     1'b0, '0},
        '{"2",     1'b0, '0},
        '{";",     1'b0, '0},                                 // extension stops scanning
        '{"f",     1'b0, '0},                                 // digit inside extension
        '{CH_LF,   1'b0, '0},
        '{8'hFF,   1'b1, '{1'b1, 1'b1, 8'hFF, 1'b0, 1'b0}},   // highest payload byte
        '{CH_LF,   1'b1, '{1'b1, 1'b1, 8'h0A, 1'b0, 1'b0}},   // lf as payload
        '{"x",     1'b0, '0},                                 // junk before line end
        '{CH_LF,   1'b0, '0},
        '{"1",     1'b0, '0},
        '{"g",     1'b0, '0},                                 // non-hex right above 'f'
        '{"9",     1'b0, '0},                                 // ignored, scan stopped
        '{CH_LF,   1'b0, '0},
        '{CH_CR,   1'b1, '{1'b1, 1'b1, 8'h0D, 1'b0, 1'b0}},   // cr as payload
        '{CH_LF,   1'b0, '0},                                 // bare lf after data
        '{"0",     1'b0, '0},
        '{"1",     1'b0, '0},
        '{CH_LF,   1'b0, '0},
        '{8'h80,   1'b1, '{1'b1, 1'b1, 8'h80, 1'b0, 1'b0}},
        '{CH_LF,   1'b0, '0}
    };

    http_chunked_decoder_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // decoder model: one byte in, one status out, state kept above
    // ------------------------------------------------------------------------
    task automatic decode_byte(input logic [7:0] b, output beat_status_t r);
        logic       is_hex;
        logic [3:0] nib;
        r = '0;
        r.consumed = 1'b1;
        is_hex = 1'b1;
        nib = '0;
        if (b >= "0" && b <= "9") begin
            nib = 4'(b - "0");
        end else if (b >= "a" && b <= "f") begin
            nib = 4'(b - "a" + 8'd10);
        end else if (b >= "A" && b <= "F") begin
            nib = 4'(b - "A" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
        case (dec_phase)
            SIZE_LINE: begin
                if (is_hex && !stop_scan) begin
                    // oversize check is made on the count before the shift
                    if (33'(chunk_left) > COUNT_LIMIT) begin
                        dec_phase = FORMAT_ERR;
                        r.consumed = 1'b0;
                    end else begin
                        chunk_left = (chunk_left << 4) + chunk_count_t'(nib);
                        got_digit = 1'b1;
                    end
                end else if (b == CH_LF) begin
                    if (!got_digit) begin
                        dec_phase = FORMAT_ERR;
                        r.consumed = 1'b0;
                    end else begin
                        stop_scan = 1'b0;
                        got_digit = 1'b0;
                        if (chunk_left == '0) begin
                            dec_phase = TRAILER;
                            blank_line = 1'b1;
                        end else begin
                            dec_phase = CHUNK_DATA;
                        end
                    end
                end else begin
                    stop_scan = 1'b1;
                end
            end
            CHUNK_DATA, DATA_CRLF: begin
                if (dec_phase == CHUNK_DATA && chunk_left != '0) begin
                    r.pvalid = 1'b1;
                    r.pbyte = b;
                    chunk_left = chunk_left - 1'b1;
                    if (chunk_left == '0) dec_phase = DATA_CRLF;
                end else if (b == CH_LF) begin
                    dec_phase = SIZE_LINE;
                    chunk_left = '0;
                end else begin
                    dec_phase = DATA_CRLF;
                end
            end
            TRAILER: begin
                if (b == CH_LF) begin
                    if (blank_line) dec_phase = BODY_DONE;
                    else blank_line = 1'b1;
                end else if (b != CH_CR) begin
                    blank_line = 1'b0;
                end
            end
            default: r.consumed = 1'b0;
        endcase
        r.done = (dec_phase == BODY_DONE);
        r.ferr = (dec_phase == FORMAT_ERR);
    endtask

    // ------------------------------------------------------------------------
    // body builder
    // ------------------------------------------------------------------------
    task automatic put(input logic [7:0] b);
        body_byte_t e;
        e.b = b;
        e.fixed = 1'b0;
        e.st = '0;
        body_q.push_back(e);
    endtask

    function automatic logic [7:0] rand_non_lf();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
        return c;
    endfunction

    // hex digits msb first, letters in random case, leading zeros included
    task automatic put_hex(input int unsigned v, input int ndig);
        logic [3:0] nib;
        for (int i = ndig - 1; i >= 0; i--) begin
            nib = 4'(v >> (4 * i));
            if (nib < 4'd10) put("0" + nib);
            else put(($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10);
        end
    endtask

    // one well-formed chunk with random size, extension, payload and line end
    task automatic add_chunk();
        int unsigned size;
        int          ndig;
        size = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 300)
                                            : $urandom_range(1, 16);
        ndig = (size > 255) ? 3 : (size > 15) ? 2 : 1;
        put_hex(size, ndig + $urandom_range(0, 2));
        case ($urandom_range(0, 7))
            0, 1: begin
                put(";");
                repeat ($urandom_range(0, 6)) put(rand_non_lf());
            end
            2: put(" ");
            default: ;
        endcase
        if ($urandom_range(0, 4) != 0) put(CH_CR);
        put(CH_LF);
        repeat (size) put(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
            0, 1: ;                                          // bare lf
            2, 3: repeat ($urandom_range(1, 4)) put(rand_non_lf());
            default: put(CH_CR);
        endcase
        put(CH_LF);
        chunks++;
    endtask

    // the body can end only once per run: last chunk and trailer, a size
    // line without digits, or an oversized count; six random bytes follow it
    task automatic add_ending();
        case ($urandom_range(0, 3))
            0, 1: begin
                ending_name = "last chunk and trailer";
                put_hex(0, $urandom_range(1, 3));
                if ($urandom_range(0, 1)) put(";");
                put(CH_CR);
                put(CH_LF);
                repeat ($urandom_range(0, 3)) begin
                    repeat ($urandom_range(1, 8)) put(8'($urandom_range(8'h20, 8'h7E)));
                    if ($urandom_range(0, 3) != 0) put(CH_CR);
                    put(CH_LF);
                end
                put(CH_CR);
                put(CH_LF);
            end
            2: begin
                ending_name = "size line without digits";
                case ($urandom_range(0, 2))
                    0: ;
                    1: put(CH_CR);
                    default: begin
                        put(";");
                        repeat ($urandom_range(0, 4)) put(rand_non_lf());
                    end
                endcase
                put(CH_LF);
            end
            default: begin
                ending_name = "oversized chunk count";
                put_hex($urandom_range(1, 15), 1);
                put_hex($urandom_range(0, 32'hFF_FFFF), 6);
                put_hex($urandom_range(0, 15), 1);
            end
        endcase
        repeat (6) put(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // reset, stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        beat_status_t st;
        body_byte_t   item;
        int           gap;
        int           idx;

        foreach (directed_tbl[i]) body_q.push_back(directed_tbl[i]);
        while (body_q.size() < 720) add_chunk();
        add_ending();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idx = 0;
        while (body_q.size() != 0) begin
            item = body_q.pop_front();
            // bursts with no gaps every so often
            gap = ((idx % 160) < 40) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= item.b;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            // beat taken at this edge
            decode_byte(item.b, st);
            expected_status_q.push_back(item.fixed ? item.st : st);
            idx++;
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;

        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("tb: %0d body bytes in %0d random chunks plus directed lines, %0d payload beats",
                 idx, chunks, payload_beats);
        $display("tb: body ended by %s, with stalls on both sides and one long hold", ending_name);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // result side ready: random holds per beat, gap-free stretches, and one
    // long hold that fills the result register and backs up the input
    initial begin
        int hold;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_beats >= 300 && !long_hold_done) begin
                hold = 64;
                long_hold_done = 1'b1;
            end else if ((rx_beats % 170) >= 130) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 3);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
        end
    endfunction

    // result beat checker, oldest expectation first
    always @(posedge aclk) begin : check_beat
        beat_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            rx_beats++;
            if (m_tuser) payload_beats++;
            if (expected_status_q.size() == 0) begin
                $error("result beat with nothing expected: tdata 'h%0h", m_tdata);
                errors++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("consumed", 8'(want.consumed), 8'(m_tdata[0]));
                check_field("payload_valid", 8'(want.pvalid), 8'(m_tuser));
                check_field("payload_byte", want.pbyte, m_tdata[8:1]);
                check_field("body_done", 8'(want.done), 8'(m_tdata[9]));
                check_field("format_error", 8'(want.ferr), 8'(m_tdata[10]));
            end
        end
    end

    // no beat on either side for too long ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("tb: timeout, no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

`default_nettype wire
